// File: hw/rtl/fclt_pkg.sv
// shared types and constants for the framed command led timer controller
// no dependencies

package fclt_pkg;

    localparam int REG_W     = 24;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 16;

    localparam logic [REG_W-1:0] TPS_RESET = 24'd3751200;
    localparam logic [REG_W-1:0] TST_RESET = 24'd62520;

    localparam logic [0:0] REG_TPS = 1'b0;
    localparam logic [0:0] REG_TST = 1'b1;

    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_A  = 8'h61;
    localparam logic [7:0] CH_B  = 8'h62;
    localparam logic [7:0] CH_C  = 8'h63;
    localparam logic [7:0] CH_D  = 8'h64;
    localparam logic [7:0] CH_E  = 8'h65;
    localparam logic [7:0] CH_F  = 8'h66;
    localparam logic [7:0] CH_G  = 8'h67;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_1  = 8'h31;
    localparam logic [7:0] CH_9  = 8'h39;

    localparam logic [1:0] BEAT_OPEN   = 2'd0;
    localparam logic [1:0] BEAT_LETTER = 2'd1;
    localparam logic [1:0] BEAT_LEVEL  = 2'd2;
    localparam logic [1:0] BEAT_CLOSE  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       reply;
        logic [1:0] beat;
    } t_cmd;

    typedef struct packed {
        logic div_start;
        logic reply;
        logic div_done;
    } t_status;

endpackage

// File: hw/rtl/fclt_div.sv
// restoring divider, one quotient bit per cycle
// depends on fclt_pkg

module fclt_div #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [fclt_pkg::REG_W-1:0] i_dividend,
    input  logic [COUNT_WIDTH-1:0]     i_divisor,
    output logic [fclt_pkg::REG_W-1:0] o_quotient,
    output logic                       o_done
);
    import fclt_pkg::*;

    localparam int CNT_W = $clog2(REG_W);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [REG_W-1:0]       r_q, n_q;
    logic [COUNT_WIDTH-1:0] r_rem, n_rem;
    logic [COUNT_WIDTH-1:0] r_dvs, n_dvs;
    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH-1:0] diff;

    assign trial = {r_rem, r_q[REG_W-1]};
    assign diff  = trial[COUNT_WIDTH-1:0] - r_dvs;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = diff;
                n_q   = {r_q[REG_W-2:0], 1'b1};
            end else begin
                n_rem = trial[COUNT_WIDTH-1:0];
                n_q   = {r_q[REG_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(REG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_quotient = r_q;
    assign o_done     = r_done;

endmodule

// File: hw/rtl/fclt_dp.sv
// datapath: frame parser, led state, blink and one-shot counters, reply byte
// depends on fclt_pkg and fclt_div

module fclt_dp #(
    parameter int MAX_FRAME_CHARS = 8,
    parameter int COUNT_WIDTH     = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fclt_pkg::t_cmd                  i_cmd,
    output fclt_pkg::t_status               o_status,
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_addr,
    input  logic [fclt_pkg::REG_W-1:0]      i_cfg_data,
    input  logic                            i_action,
    input  logic [fclt_pkg::IN_DATA_W-1:0]  i_rx_byte,
    output logic [fclt_pkg::OUT_DATA_W-1:0] o_tdata
);
    import fclt_pkg::*;

    localparam int FC_W = $clog2(MAX_FRAME_CHARS + 1);
    localparam int WW   = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                   r_action;
    logic [7:0]             r_ch;
    logic [REG_W-1:0]       r_tps, r_tst;

    logic                   r_in_frame, n_in_frame;
    logic [FC_W-1:0]        r_fcount, n_fcount;
    logic [7:0]             r_letter, n_letter;
    logic [COUNT_WIDTH-1:0] r_acc, n_acc;
    logic                   r_green, n_green;
    logic                   r_yellow, n_yellow;
    logic                   r_red, n_red;
    logic                   r_blink_en, n_blink_en;
    logic [REG_W-1:0]       r_blink_thr, n_blink_thr;
    logic [COUNT_WIDTH-1:0] r_blink_ticks, n_blink_ticks;
    logic                   r_os_en, n_os_en;
    logic [COUNT_WIDTH-1:0] r_os_dur, n_os_dur;
    logic [COUNT_WIDTH-1:0] r_os_steps, n_os_steps;
    logic [COUNT_WIDTH-1:0] r_os_ticks, n_os_ticks;

    logic                   frame_end;
    logic [COUNT_WIDTH-1:0] blink_inc, os_inc, steps_inc;
    logic [3:0]             digit;
    logic [COUNT_WIDTH+3:0] acc_next;
    logic [COUNT_WIDTH-1:0] divisor;
    logic [REG_W-1:0]       quotient;
    logic                   div_done;
    logic [7:0]             tx_byte;

    assign frame_end = !r_action && r_in_frame && (r_ch == CH_GT) && (r_fcount != '0);
    assign o_status.div_start = frame_end && (r_letter == CH_F);
    assign o_status.reply     = frame_end && (r_letter == CH_E);
    assign o_status.div_done  = div_done;

    assign divisor = (r_acc == '0) ? COUNT_WIDTH'(1) : r_acc;

    fclt_div #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.step && o_status.div_start),
        .i_dividend (r_tps),
        .i_divisor  (divisor),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    assign blink_inc = (r_blink_ticks == CNT_MAX) ? r_blink_ticks : r_blink_ticks + 1'b1;
    assign os_inc    = (r_os_ticks == CNT_MAX) ? r_os_ticks : r_os_ticks + 1'b1;
    assign steps_inc = (r_os_steps == CNT_MAX) ? r_os_steps : r_os_steps + 1'b1;
    assign digit     = (r_ch >= CH_0 && r_ch <= CH_9) ? 4'(r_ch - CH_0) : 4'd0;
    assign acc_next  = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                     + (COUNT_WIDTH+4)'(digit);

    always_comb begin
        n_in_frame    = r_in_frame;
        n_fcount      = r_fcount;
        n_letter      = r_letter;
        n_acc         = r_acc;
        n_green       = r_green;
        n_yellow      = r_yellow;
        n_red         = r_red;
        n_blink_en    = r_blink_en;
        n_blink_thr   = r_blink_thr;
        n_blink_ticks = r_blink_ticks;
        n_os_en       = r_os_en;
        n_os_dur      = r_os_dur;
        n_os_steps    = r_os_steps;
        n_os_ticks    = r_os_ticks;
        if (div_done) begin
            n_blink_thr = quotient;
        end
        if (i_cmd.step) begin
            if (r_action) begin
                n_blink_ticks = blink_inc;
                n_os_ticks    = os_inc;
                if (r_blink_en && (WW'(blink_inc) >= WW'(r_blink_thr))) begin
                    n_red         = !r_red;
                    n_blink_ticks = '0;
                end
                if (r_os_en && (WW'(os_inc) >= WW'(r_tst))) begin
                    n_os_steps = steps_inc;
                    if (steps_inc >= r_os_dur) begin
                        n_yellow = !r_yellow;
                        n_os_en  = 1'b0;
                    end
                    n_os_ticks = '0;
                end
            end else if (!r_in_frame) begin
                if (r_ch == CH_LT) begin
                    n_in_frame = 1'b1;
                    n_fcount   = '0;
                    n_letter   = '0;
                    n_acc      = '0;
                end
            end else if (r_ch == CH_GT) begin
                n_in_frame = 1'b0;
                if (r_fcount != '0) begin
                    unique case (r_letter)
                        CH_A: n_green = 1'b1;
                        CH_B: n_green = 1'b0;
                        CH_C: begin
                            n_os_en    = 1'b1;
                            n_os_dur   = r_acc;
                            n_os_steps = '0;
                            n_os_ticks = '0;
                            n_yellow   = 1'b1;
                        end
                        CH_D: begin
                            n_os_en  = 1'b0;
                            n_yellow = 1'b0;
                        end
                        CH_F: begin
                            n_blink_en    = 1'b1;
                            n_red         = 1'b1;
                            n_blink_ticks = '0;
                        end
                        CH_G: begin
                            n_blink_en = 1'b0;
                            n_red      = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end else if (r_fcount < FC_W'(MAX_FRAME_CHARS)) begin
                if (r_fcount == '0) begin
                    n_letter = r_ch;
                end else begin
                    n_acc = (acc_next[COUNT_WIDTH+3:COUNT_WIDTH] != '0)
                          ? CNT_MAX : acc_next[COUNT_WIDTH-1:0];
                end
                n_fcount = r_fcount + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps         <= TPS_RESET;
            r_tst         <= TST_RESET;
            r_in_frame    <= 1'b0;
            r_fcount      <= '0;
            r_letter      <= '0;
            r_acc         <= '0;
            r_green       <= 1'b0;
            r_yellow      <= 1'b0;
            r_red         <= 1'b0;
            r_blink_en    <= 1'b0;
            r_blink_thr   <= TPS_RESET;
            r_blink_ticks <= '0;
            r_os_en       <= 1'b0;
            r_os_dur      <= COUNT_WIDTH'(1);
            r_os_steps    <= '0;
            r_os_ticks    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_TPS: r_tps <= i_cfg_data;
                    REG_TST: r_tst <= i_cfg_data;
                    default: ;
                endcase
            end
            r_in_frame    <= n_in_frame;
            r_fcount      <= n_fcount;
            r_letter      <= n_letter;
            r_acc         <= n_acc;
            r_green       <= n_green;
            r_yellow      <= n_yellow;
            r_red         <= n_red;
            r_blink_en    <= n_blink_en;
            r_blink_thr   <= n_blink_thr;
            r_blink_ticks <= n_blink_ticks;
            r_os_en       <= n_os_en;
            r_os_dur      <= n_os_dur;
            r_os_steps    <= n_os_steps;
            r_os_ticks    <= n_os_ticks;
        end
        if (i_cmd.load) begin
            r_action <= i_action;
            r_ch     <= i_rx_byte;
        end
    end

    always_comb begin
        tx_byte = '0;
        if (i_cmd.reply) begin
            unique case (i_cmd.beat)
                BEAT_OPEN:   tx_byte = CH_LT;
                BEAT_LETTER: tx_byte = CH_E;
                BEAT_LEVEL:  tx_byte = r_yellow ? CH_1 : CH_0;
                BEAT_CLOSE:  tx_byte = CH_GT;
                default:     tx_byte = '0;
            endcase
        end
    end

    assign o_tdata = {4'd0, r_red, r_yellow, r_green, tx_byte, i_cmd.reply};

endmodule

// File: hw/rtl/fclt_ctrl.sv
// controller state machine: accept, step, divider wait, result beats
// depends on fclt_pkg

module fclt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic              o_m_axis_tlast,
    output fclt_pkg::t_cmd    o_cmd,
    input  fclt_pkg::t_status i_status
);
    import fclt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_reply, n_reply;
    logic [1:0] r_beat, n_beat;
    logic       last_beat;

    assign last_beat = !r_reply || (r_beat == BEAT_CLOSE);

    always_comb begin
        n_state = r_state;
        n_reply = r_reply;
        n_beat  = r_beat;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_reply = i_status.reply;
                n_beat  = BEAT_OPEN;
                n_state = i_status.div_start ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_m_axis_tready) begin
                    if (last_beat) begin
                        n_state = S_IDLE;
                    end else begin
                        n_beat = r_beat + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_reply <= 1'b0;
            r_beat  <= BEAT_OPEN;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
            r_beat  <= n_beat;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tlast  = last_beat;
    assign o_cmd.load      = (r_state == S_IDLE) && i_s_axis_tvalid;
    assign o_cmd.step      = (r_state == S_STEP);
    assign o_cmd.reply     = r_reply;
    assign o_cmd.beat      = r_beat;

endmodule

// File: hw/rtl/framed_command_led_timer_controller.sv
// framed command led timer controller, top level
// an input beat is registered on accept, applied in the step state and then sent as its first
// result beat; when an f frame ends, the output waits for the 24-iteration restoring divider
// that computes the blink period; the input is not ready again until the last result beat is taken
// reset: synchronous active-low i_rst_n clears the control and led state and loads the register defaults
// depends on fclt_pkg, fclt_ctrl, fclt_dp, fclt_div

module framed_command_led_timer_controller #(
    parameter int MAX_FRAME_CHARS = 8,
    parameter int COUNT_WIDTH     = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [7:0] rx_byte
    input  logic [fclt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] action
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] green led, [10] yellow led, [11] red led
    output logic [fclt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                            o_m_axis_tlast,
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_addr,
    input  logic [fclt_pkg::REG_W-1:0]      i_cfg_data
);
    import fclt_pkg::*;

    t_cmd    cmd;
    t_status status;

    fclt_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_cmd           (cmd),
        .i_status        (status)
    );

    fclt_dp #(
        .MAX_FRAME_CHARS (MAX_FRAME_CHARS),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_action   (i_s_axis_tuser),
        .i_rx_byte  (i_s_axis_tdata),
        .o_tdata    (o_m_axis_tdata)
    );

endmodule

// File: test/tb_framed_command_led_timer_controller.sv
// testbench for framed_command_led_timer_controller: streams command frames and timer ticks
// with random gaps and stalls, predicts each result beat and compares it with the output stream
// depends on fclt_pkg and the controller rtl

module tb_framed_command_led_timer_controller;
    import fclt_pkg::*;

    localparam int FRAME_CHARS = 8;
    localparam int CNT_W       = 24;
    localparam int STALL_MAX   = 19;
    localparam int SETTLE      = 40;
    localparam int WATCHDOG    = 2000;

    typedef struct packed {
        logic       tick;
        logic [7:0] ch;
    } t_rx_item;

    typedef struct packed {
        logic       last;
        logic [3:0] pad;
        logic       red;
        logic       yellow;
        logic       green;
        logic [7:0] tx_char;
        logic       tx_valid;
    } t_led_beat;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_valid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_data   = '0;
    logic                  s_user   = 1'b0;
    logic                  m_ready  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [0:0]            cfg_addr = '0;
    logic [REG_W-1:0]      cfg_data = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_last;
    logic [OUT_DATA_W-1:0] m_data;

    // predictor copy of registers and state
    logic [REG_W-1:0] cfg_tps  = TPS_RESET;
    logic [REG_W-1:0] cfg_step = TST_RESET;
    logic             frm_open = 1'b0;
    int               frm_len  = 0;
    logic [7:0]       frm_cmd  = '0;
    logic [CNT_W-1:0] frm_num  = '0;
    logic             led_g    = 1'b0;
    logic             led_y    = 1'b0;
    logic             led_r    = 1'b0;
    logic             blink_on = 1'b0;
    logic [CNT_W-1:0] blink_limit = TPS_RESET;
    logic [CNT_W-1:0] blink_cnt   = '0;
    logic             shot_on     = 1'b0;
    logic [CNT_W-1:0] shot_len    = CNT_W'(1);
    logic [CNT_W-1:0] shot_steps  = '0;
    logic [CNT_W-1:0] shot_cnt    = '0;

    t_rx_item  rx_queue[$];
    t_led_beat beats_due[$];
    t_rx_item  src_item;
    t_led_beat beat_seen;
    t_led_beat beat_want;
    logic      src_busy  = 1'b0;
    logic      src_lazy  = 1'b1;
    int        src_gap   = 0;
    logic      sink_lazy = 1'b1;
    int        sink_gap  = 0;
    int        mismatches   = 0;
    int        quiet_cycles = 0;

    framed_command_led_timer_controller DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic void queue_beat(input logic valid, input logic [7:0] ch, input logic fin);
        t_led_beat b;
        b          = '0;
        b.last     = fin;
        b.red      = led_r;
        b.yellow   = led_y;
        b.green    = led_g;
        b.tx_char  = valid ? ch : 8'h00;
        b.tx_valid = valid;
        beats_due.push_back(b);
    endfunction

    task automatic predict_controller(input t_rx_item it);
        logic        reply;
        logic [31:0] acc;
        logic [7:0]  digit;
        reply = 1'b0;
        if (it.tick) begin
            blink_cnt = sat_inc(blink_cnt);
            shot_cnt  = sat_inc(shot_cnt);
            if (blink_on && blink_cnt >= blink_limit) begin
                led_r     = !led_r;
                blink_cnt = '0;
            end
            if (shot_on && shot_cnt >= cfg_step) begin
                shot_steps = sat_inc(shot_steps);
                if (shot_steps >= shot_len) begin
                    led_y   = !led_y;
                    shot_on = 1'b0;
                end
                shot_cnt = '0;
            end
        end else if (!frm_open) begin
            if (it.ch == CH_LT) begin
                frm_open = 1'b1;
                frm_len  = 0;
                frm_cmd  = '0;
                frm_num  = '0;
            end
        end else if (it.ch == CH_GT) begin
            frm_open = 1'b0;
            if (frm_len > 0) begin
                case (frm_cmd)
                    CH_A: led_g = 1'b1;
                    CH_B: led_g = 1'b0;
                    CH_C: begin
                        shot_on    = 1'b1;
                        shot_len   = frm_num;
                        shot_steps = '0;
                        shot_cnt   = '0;
                        led_y      = 1'b1;
                    end
                    CH_D: begin
                        shot_on = 1'b0;
                        led_y   = 1'b0;
                    end
                    CH_E: reply = 1'b1;
                    CH_F: begin
                        blink_on    = 1'b1;
                        blink_limit = cfg_tps / ((frm_num == '0) ? 24'd1 : frm_num);
                        led_r       = 1'b1;
                        blink_cnt   = '0;
                    end
                    CH_G: begin
                        blink_on = 1'b0;
                        led_r    = 1'b0;
                    end
                    default: ;
                endcase
            end
        end else if (frm_len < FRAME_CHARS) begin
            if (frm_len == 0) begin
                frm_cmd = it.ch;
            end else begin
                digit   = (it.ch >= CH_0 && it.ch <= CH_9) ? it.ch - CH_0 : 8'd0;
                acc     = frm_num * 32'd10 + digit;
                frm_num = (acc > 32'hFF_FFFF) ? '1 : acc[CNT_W-1:0];
            end
            frm_len++;
        end

        if (reply) begin
            queue_beat(1'b1, CH_LT, 1'b0);
            queue_beat(1'b1, CH_E, 1'b0);
            queue_beat(1'b1, led_y ? CH_1 : CH_0, 1'b0);
            queue_beat(1'b1, CH_GT, 1'b1);
        end else begin
            queue_beat(1'b0, 8'h00, 1'b1);
        end
    endtask

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid  <= 1'b0;
            src_busy = 1'b0;
            src_gap  = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_controller(src_item);
                src_busy = 1'b0;
            end
            if (!src_busy) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (rx_queue.size() != 0) begin
                    src_item = rx_queue.pop_front();
                    s_user   <= src_item.tick;
                    s_data   <= src_item.ch;
                    s_valid  <= 1'b1;
                    src_busy = 1'b1;
                    if ($urandom_range(0, 31) == 0) src_lazy = !src_lazy;
                    src_gap = src_lazy ? $urandom_range(0, STALL_MAX) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready  <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                beat_seen = {m_last, m_data};
                if (beats_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected beat: data=%h last=%0b", m_data, m_last);
                    mismatches++;
                end else begin
                    beat_want = beats_due.pop_front();
                    if (beat_seen !== beat_want) begin
                        if (mismatches < 10) begin
                            $display("beat mismatch: expected valid=%0b char=%h last=%0b g=%0b y=%0b r=%0b pad=%h",
                                     beat_want.tx_valid, beat_want.tx_char, beat_want.last,
                                     beat_want.green, beat_want.yellow, beat_want.red,
                                     beat_want.pad);
                            $display("               got valid=%0b char=%h last=%0b g=%0b y=%0b r=%0b pad=%h",
                                     beat_seen.tx_valid, beat_seen.tx_char, beat_seen.last,
                                     beat_seen.green, beat_seen.yellow, beat_seen.red,
                                     beat_seen.pad);
                        end
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 31) == 0) sink_lazy = !sink_lazy;
                sink_gap = sink_lazy ? $urandom_range(0, STALL_MAX) : 0;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("framed_command_led_timer_controller: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_item(input logic tick, input logic [7:0] ch);
        t_rx_item it;
        it.tick = tick;
        it.ch   = ch;
        rx_queue.push_back(it);
    endtask

    task automatic add_frame(input logic [7:0] letter, input int unsigned value,
                             input bit with_num);
        logic [7:0]  digits[$];
        int unsigned v;
        v = value;
        add_item(1'b0, CH_LT);
        add_item(1'b0, letter);
        if (with_num) begin
            digits.push_front(CH_0 + 8'(v % 10));
            v = v / 10;
            while (v != 0) begin
                digits.push_front(CH_0 + 8'(v % 10));
                v = v / 10;
            end
            foreach (digits[i]) add_item(1'b0, digits[i]);
        end
        add_item(1'b0, CH_GT);
    endtask

    task automatic set_rates(input logic [REG_W-1:0] tps, input logic [REG_W-1:0] step);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_TPS;
        cfg_data <= tps;
        cfg_tps  = tps;
        @(posedge i_clk);
        cfg_addr <= REG_TST;
        cfg_data <= step;
        cfg_step = step;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (rx_queue.size() != 0 || src_busy || beats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic add_random(input int target);
        int          made;
        int          k;
        int          n;
        int unsigned val;
        logic [7:0]  letter;
        logic [7:0]  ch;
        made = 0;
        while (made < target) begin
            k = rx_queue.size();
            if ($urandom_range(0, 99) < 55) begin
                letter = CH_A + 8'($urandom_range(0, 6));
                if (letter == CH_C)
                    val = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 4)
                                                       : $urandom_range(0, 20);
                else if (letter == CH_F)
                    val = ($urandom_range(0, 5) != 0) ? $urandom_range(0, 40)
                                                       : $urandom_range(0, 9999999);
                else
                    val = $urandom_range(0, 99);
                add_frame(letter, val, $urandom_range(0, 3) != 0);
            end else if ($urandom_range(0, 99) < 55) begin
                n = $urandom_range(1, 8);
                repeat (n) add_item(1'b1, 8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 5))
                    0: begin
                        // stray byte outside a frame
                        ch = 8'($urandom_range(0, 255));
                        if (ch == CH_LT) ch = 8'hFF;
                        add_item(1'b0, ch);
                    end
                    1: begin
                        ch = 8'($urandom_range(0, 255));
                        if (ch == CH_GT) ch = 8'h00;
                        add_frame(ch, $urandom_range(0, 999), $urandom_range(0, 1) != 0);
                    end
                    2: begin
                        // junk in the number field
                        add_item(1'b0, CH_LT);
                        add_item(1'b0, CH_A + 8'($urandom_range(0, 6)));
                        n = $urandom_range(1, 7);
                        repeat (n) begin
                            ch = 8'($urandom_range(0, 255));
                            if (ch == CH_GT) ch = 8'hFF;
                            add_item(1'b0, ch);
                        end
                        add_item(1'b0, CH_GT);
                    end
                    3: begin
                        // too many characters, tail dropped
                        add_item(1'b0, CH_LT);
                        add_item(1'b0, CH_A + 8'($urandom_range(0, 6)));
                        n = $urandom_range(8, 12);
                        repeat (n) add_item(1'b0, CH_0 + 8'($urandom_range(0, 9)));
                        add_item(1'b0, CH_GT);
                    end
                    4: begin
                        add_item(1'b0, CH_LT);
                        add_item(1'b0, ($urandom_range(0, 1) != 0)
                                       ? CH_LT : CH_A + 8'($urandom_range(0, 6)));
                        add_item(1'b0, CH_LT);
                        add_item(1'b0, CH_0 + 8'($urandom_range(0, 9)));
                        add_item(1'b0, CH_GT);
                    end
                    default: begin
                        add_item(1'b0, CH_LT);
                        add_item(1'b0, CH_GT);
                    end
                endcase
            end
            made += rx_queue.size() - k;
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lowest rates: both rate registers at one, so single-tick steps
        set_rates(24'd1, 24'd1);
        add_item(1'b0, 8'h00);
        add_item(1'b0, 8'hFF);
        add_item(1'b0, CH_LT);
        add_item(1'b0, CH_GT);
        add_frame(CH_A, 0, 1'b0);
        add_frame(CH_E, 0, 1'b0);
        add_frame(CH_C, 0, 1'b1);
        add_item(1'b1, 8'hFF);
        add_item(1'b1, 8'h00);
        add_frame(CH_F, 0, 1'b1);
        add_item(1'b1, 8'h5A);
        add_frame(CH_G, 0, 1'b0);
        add_frame(CH_B, 0, 1'b0);
        add_frame(CH_D, 0, 1'b0);
        add_random(40);
        drain();

        set_rates(24'hFF_FFFF, 24'hFF_FFFF);
        add_random(30);
        drain();

        set_rates(24'($urandom_range(2, 60)), 24'($urandom_range(1, 6)));
        add_random(60);
        drain();

        set_rates(24'($urandom_range(1, 24'hFF_FFFF)), 24'($urandom_range(1, 3)));
        add_random(50);
        drain();

        if (mismatches == 0 && beats_due.size() == 0) begin
            $display("framed_command_led_timer_controller: match");
        end else begin
            $display("framed_command_led_timer_controller: mismatch");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/fclt_pkg.sv
hw/rtl/fclt_div.sv
hw/rtl/fclt_dp.sv
hw/rtl/fclt_ctrl.sv
hw/rtl/framed_command_led_timer_controller.sv
test/tb_framed_command_led_timer_controller.sv
